// ===== sv/dmoi_pkg.sv =====
package dmoi_pkg;

    // fixed point formats
    localparam int FRACTION_BITS     = 16;
    localparam int POSITION_WIDTH    = 48;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int SCALE_BITS        = 24;
    localparam int ROUND_SHIFT       = SCALE_BITS - FRACTION_BITS;
    localparam int ITER_W            = 5;
    localparam int CW                = 36;   // CORDIC vector width
    localparam int ZW                = 33;   // CORDIC residual angle width
    localparam int CFG_IDX_W         = 3;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_LATERAL  = 3'd0,
        REG_LEFT_FORWARD  = 3'd1,
        REG_RIGHT_LATERAL = 3'd2,
        REG_RIGHT_FORWARD = 3'd3,
        REG_ROTATION      = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MXL, ST_MYL, ST_MXR, ST_MYR, ST_SUM, ST_MRLO, ST_MRHI,
        ST_ROT, ST_MID, ST_GX, ST_GY, ST_QUAD, ST_ITER, ST_UPD, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MXL, OP_MYL, OP_MXR, OP_MYR, OP_SUM, OP_MRLO,
        OP_MRHI, OP_ROT, OP_MID, OP_GX, OP_GY, OP_QUAD, OP_ITER, OP_UPD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    // arctangent of 2^-i in binary angle units
    function automatic logic [29:0] atan_units(input logic [ITER_W-1:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/dmoi_ctrl.sv =====
module dmoi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_stall,
    output logic          in_stall,
    output logic          out_valid,
    output dmoi_pkg::cmd_t cmd
);
    import dmoi_pkg::*;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    // state and iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MXL;
            ST_MXL:  state_next = ST_MYL;
            ST_MYL:  state_next = ST_MXR;
            ST_MXR:  state_next = ST_MYR;
            ST_MYR:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_MRLO;
            ST_MRLO: state_next = ST_MRHI;
            ST_MRHI: state_next = ST_ROT;
            ST_ROT:  state_next = ST_MID;
            ST_MID:  state_next = ST_GX;
            ST_GX:   state_next = ST_GY;
            ST_GY:   state_next = ST_QUAD;
            ST_QUAD:
            begin
                state_next = ST_ITER;
                iter_next  = '0;
            end
            ST_ITER:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_ITERATIONS - 1))
                    state_next = ST_UPD;
            end
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        cmd.iter  = iter_reg;
        unique case (state_reg)
            ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
            ST_MXL:  cmd.op = OP_MXL;
            ST_MYL:  cmd.op = OP_MYL;
            ST_MXR:  cmd.op = OP_MXR;
            ST_MYR:  cmd.op = OP_MYR;
            ST_SUM:  cmd.op = OP_SUM;
            ST_MRLO: cmd.op = OP_MRLO;
            ST_MRHI: cmd.op = OP_MRHI;
            ST_ROT:  cmd.op = OP_ROT;
            ST_MID:  cmd.op = OP_MID;
            ST_GX:   cmd.op = OP_GX;
            ST_GY:   cmd.op = OP_GY;
            ST_QUAD: cmd.op = OP_QUAD;
            ST_ITER: cmd.op = OP_ITER;
            ST_UPD:  cmd.op = OP_UPD;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== sv/dmoi_datapath.sv =====
module dmoi_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmoi_pkg::cmd_t                       cmd,
    input  logic                                 cfg_we,
    input  logic [dmoi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmoi_pkg::SCALE_BITS-1:0]      cfg_data,
    input  logic                                 restart,
    input  logic signed [15:0]                   dx_left,
    input  logic signed [15:0]                   dy_left,
    input  logic signed [15:0]                   dx_right,
    input  logic signed [15:0]                   dy_right,
    output logic signed [31:0]                   lateral_step,
    output logic signed [31:0]                   forward_step,
    output logic signed [31:0]                   rotation_step,
    output logic signed [dmoi_pkg::POSITION_WIDTH-1:0] position_x,
    output logic signed [dmoi_pkg::POSITION_WIDTH-1:0] position_y,
    output logic [31:0]                          heading
);
    import dmoi_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam logic signed [PW+1:0] POS_HI = (PW+2)'((64'd1 << (PW - 1)) - 64'd1);
    localparam logic signed [PW+1:0] POS_LO = -POS_HI - (PW+2)'(1);

    // configuration
    logic [SCALE_BITS-1:0] lls_reg, lfs_reg, rls_reg, rfs_reg, rs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lls_reg <= 24'd53361;
            lfs_reg <= 24'd54588;
            rls_reg <= 24'd51743;
            rfs_reg <= 24'd52169;
            rs_reg  <= 24'd4882609;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                REG_LEFT_LATERAL:  lls_reg <= cfg_data;
                REG_LEFT_FORWARD:  lfs_reg <= cfg_data;
                REG_RIGHT_LATERAL: rls_reg <= cfg_data;
                REG_RIGHT_FORWARD: rfs_reg <= cfg_data;
                REG_ROTATION:      rs_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // working registers
    logic signed [15:0] dxl_reg, dyl_reg, dxr_reg, dyr_reg;
    logic signed [39:0] pxl_reg, pyl_reg, pxr_reg, pyr_reg;
    logic signed [31:0] lat_reg, fwd_reg;
    logic signed [40:0] diff_reg;
    logic [47:0]        prl_reg;
    logic signed [40:0] prh_reg;
    logic [31:0]        rot_reg;
    logic [1:0]         quad_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [61:0] gx_reg, gy_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [PW-1:0] pose_x_reg, pose_y_reg;
    logic [31:0]        head_reg;

    // shared multiplier operand select
    logic signed [32:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [63:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MXL:  begin mul_a = 33'(dxl_reg); mul_b = {7'd0, lls_reg}; end
            OP_MYL:  begin mul_a = 33'(dyl_reg); mul_b = {7'd0, lfs_reg}; end
            OP_MXR:  begin mul_a = 33'(dxr_reg); mul_b = {7'd0, rls_reg}; end
            OP_MYR:  begin mul_a = 33'(dyr_reg); mul_b = {7'd0, rfs_reg}; end
            OP_MRLO: begin mul_a = {9'd0, diff_reg[23:0]}; mul_b = {7'd0, rs_reg}; end
            OP_MRHI: begin mul_a = 33'($signed(diff_reg[40:24])); mul_b = {7'd0, rs_reg}; end
            OP_GX:   begin mul_a = 33'(lat_reg); mul_b = {1'b0, INV_GAIN_Q30}; end
            OP_GY:   begin mul_a = 33'(fwd_reg); mul_b = {1'b0, INV_GAIN_Q30}; end
            default: ;
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // step sums with rounding and saturation
    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [41:0] hi;
        logic signed [41:0] lo;
        hi = 42'sd2147483647;
        lo = -42'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic signed [41:0] lat_sum, fwd_sum;
    logic [55:0]        rot_sum;
    logic [31:0]        mid_s;
    logic signed [61:0] gx_rnd, gy_rnd;
    logic signed [CW-1:0] gx_c, gy_c, qx, qy;
    logic signed [CW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] atan_z;
    logic signed [PW+1:0] nx_sum, ny_sum;

    always_comb
    begin
        lat_sum = (42'(pxl_reg) + 42'(pxr_reg) + (42'sd1 <<< ROUND_SHIFT))
                  >>> (ROUND_SHIFT + 1);
        fwd_sum = (-42'(pyl_reg) - 42'(pyr_reg) + (42'sd1 <<< ROUND_SHIFT))
                  >>> (ROUND_SHIFT + 1);
        rot_sum = {8'd0, prl_reg} + {prh_reg[31:0], 24'd0} + 56'(1 << 23);
        mid_s   = head_reg + {rot_reg[31], rot_reg[31:1]} + 32'h2000_0000;

        // remove CORDIC gain, round, then coarse quadrant turn
        gx_rnd = (gx_reg + 62'(1 << 29)) >>> 30;
        gy_rnd = (gy_reg + 62'(1 << 29)) >>> 30;
        gx_c   = CW'($signed(gx_rnd[31:0]));
        gy_c   = CW'($signed(gy_rnd[31:0]));
        unique case (quad_reg)
            2'd1:    begin qx = -gy_c; qy = gx_c;  end
            2'd2:    begin qx = -gx_c; qy = -gy_c; end
            2'd3:    begin qx = gy_c;  qy = -gx_c; end
            default: begin qx = gx_c;  qy = gy_c;  end
        endcase

        // micro-rotation terms
        sh_x   = x_reg >>> cmd.iter;
        sh_y   = y_reg >>> cmd.iter;
        atan_z = ZW'(atan_units(cmd.iter));

        // pose accumulate
        nx_sum = (PW+2)'(pose_x_reg) + (PW+2)'(x_reg);
        ny_sum = (PW+2)'(pose_y_reg) + (PW+2)'(y_reg);
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dxl_reg    <= '0;
            dyl_reg    <= '0;
            dxr_reg    <= '0;
            dyr_reg    <= '0;
            pxl_reg    <= '0;
            pyl_reg    <= '0;
            pxr_reg    <= '0;
            pyr_reg    <= '0;
            lat_reg    <= '0;
            fwd_reg    <= '0;
            diff_reg   <= '0;
            prl_reg    <= '0;
            prh_reg    <= '0;
            rot_reg    <= '0;
            quad_reg   <= '0;
            z_reg      <= '0;
            gx_reg     <= '0;
            gy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            head_reg   <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    dxl_reg <= dx_left;
                    dyl_reg <= dy_left;
                    dxr_reg <= dx_right;
                    dyr_reg <= dy_right;
                    if (restart)
                    begin
                        pose_x_reg <= '0;
                        pose_y_reg <= '0;
                        head_reg   <= '0;
                    end
                end
                OP_MXL:  pxl_reg <= mul_p[39:0];
                OP_MYL:  pyl_reg <= mul_p[39:0];
                OP_MXR:  pxr_reg <= mul_p[39:0];
                OP_MYR:  pyr_reg <= mul_p[39:0];
                OP_SUM:
                begin
                    lat_reg  <= sat32(lat_sum);
                    fwd_reg  <= sat32(fwd_sum);
                    diff_reg <= 41'(pyl_reg) - 41'(pyr_reg);
                end
                OP_MRLO: prl_reg <= mul_p[47:0];
                OP_MRHI: prh_reg <= mul_p[40:0];
                OP_ROT:  rot_reg <= rot_sum[55:24];
                OP_MID:
                begin
                    quad_reg <= mid_s[31:30];
                    z_reg    <= ZW'({1'b0, mid_s[29:0]}) - ZW'(32'h2000_0000);
                end
                OP_GX:   gx_reg <= mul_p[61:0];
                OP_GY:   gy_reg <= mul_p[61:0];
                OP_QUAD:
                begin
                    x_reg <= qx;
                    y_reg <= qy;
                end
                OP_ITER:
                begin
                    if (!z_reg[ZW-1])
                    begin
                        x_reg <= x_reg - sh_y;
                        y_reg <= y_reg + sh_x;
                        z_reg <= z_reg - atan_z;
                    end
                    else
                    begin
                        x_reg <= x_reg + sh_y;
                        y_reg <= y_reg - sh_x;
                        z_reg <= z_reg + atan_z;
                    end
                end
                OP_UPD:
                begin
                    if (nx_sum > POS_HI)
                        pose_x_reg <= POS_HI[PW-1:0];
                    else if (nx_sum < POS_LO)
                        pose_x_reg <= POS_LO[PW-1:0];
                    else
                        pose_x_reg <= nx_sum[PW-1:0];
                    if (ny_sum > POS_HI)
                        pose_y_reg <= POS_HI[PW-1:0];
                    else if (ny_sum < POS_LO)
                        pose_y_reg <= POS_LO[PW-1:0];
                    else
                        pose_y_reg <= ny_sum[PW-1:0];
                    head_reg <= head_reg + rot_reg;
                end
                default: ;
            endcase
        end
    end

    // result beat fields
    assign lateral_step  = lat_reg;
    assign forward_step  = fwd_reg;
    assign rotation_step = rot_reg;
    assign position_x    = pose_x_reg;
    assign position_y    = pose_y_reg;
    assign heading       = head_reg;

endmodule

// ===== sv/dual_mouse_odometry_integrator_core.sv =====
// The result beat is offered after the scale multiplies, the CORDIC rotation
// and the pose update; a new item waits until the last result is taken. The
// sixteen-step CORDIC rotator and the single shared multiplier bound the rate.
// Reset (rst_n, async, active low) zeroes the pose and loads the default scales.
// The block takes one item at a time; in_stall is high until the result is taken.
module dual_mouse_odometry_integrator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  restart,
    input  logic signed [15:0]                    dx_left,
    input  logic signed [15:0]                    dy_left,
    input  logic signed [15:0]                    dx_right,
    input  logic signed [15:0]                    dy_right,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [31:0]                    lateral_step,
    output logic signed [31:0]                    forward_step,
    output logic signed [31:0]                    rotation_step,
    output logic signed [dmoi_pkg::POSITION_WIDTH-1:0] position_x,
    output logic signed [dmoi_pkg::POSITION_WIDTH-1:0] position_y,
    output logic [31:0]                           heading,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dmoi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dmoi_pkg::SCALE_BITS-1:0]       cfg_data
);
    import dmoi_pkg::*;

    cmd_t cmd;

    // config writes always taken
    assign cfg_ready = 1'b1;

    dmoi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    dmoi_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .restart       (restart),
        .dx_left       (dx_left),
        .dy_left       (dy_left),
        .dx_right      (dx_right),
        .dy_right      (dy_right),
        .lateral_step  (lateral_step),
        .forward_step  (forward_step),
        .rotation_step (rotation_step),
        .position_x    (position_x),
        .position_y    (position_y),
        .heading       (heading)
    );

endmodule
